>>> hw/rtl/pwmt_pkg.sv
// Shared types, constants and command codes for the PWM timer.
`default_nettype none
package pwmt_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CHANNELS    = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESCALER  = 3'd0,
    REG_RELOAD     = 3'd1,
    REG_REPETITION = 3'd2,
    REG_COUNT_DOWN = 3'd3,
    REG_COMPARE1   = 3'd4,
    REG_COMPARE2   = 3'd5,
    REG_COMPARE3   = 3'd6,
    REG_COMPARE4   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] command;
    logic       irq_enable;
  } in_word_t;

  typedef struct packed {
    logic [15:0] count_value;
    logic        pwm_ch1;
    logic        pwm_ch2;
    logic        pwm_ch3;
    logic        pwm_ch4;
    logic        update_flag;
    logic        interrupt_request;
    logic        running;
  } out_word_t;

  typedef struct packed {
    logic [15:0]      prescaler;
    logic [15:0]      reload;
    logic [7:0]       repetition;
    logic             count_down;
    logic [3:0][15:0] compare;
  } cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/pwm_timer_with_repetition.sv
// PWM timer with repetition counter: top level with input and result registers.
//
// Usage
//   Input channel (in_valid / in_stall / in_data): one command word per item,
//   tick, start, stop or clear update flag, with irq_enable used by start.
//   Result channel (out_valid / out_stall / out_data): exactly one word per
//   input word, carrying the counter value, four PWM levels, the sticky
//   update flag, the interrupt pulse and the running status.
//   Config port (cfg_we / cfg_index / cfg_data): single-cycle register writes,
//   to be made only while no word is in flight.
// Timing
//   An accepted word is captured by the input register, then the timer logic
//   feeds the result register from it once that register is free or draining.
//   Throughput is one word per cycle while the result channel does not stall,
//   set by the state update of the timer core.
// Reset
//   Synchronous, active low rst_n: both stages empty, timer stopped, all
//   counters and flags zero, config registers at their reset values.
// Stall
//   A stalled result holds; the input register keeps its word and in_stall
//   rises only once that register is full and cannot drain.
`default_nettype none
module pwm_timer_with_repetition (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire pwmt_pkg::in_word_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output pwmt_pkg::out_word_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [pwmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pwmt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pwmt_pkg::*;

  cfg_t      cfg;
  in_word_t  in_r;
  logic      in_vld_r;
  out_word_t out_r;
  out_word_t result;
  logic      out_vld_r;
  logic      adv;
  logic      in_take;

  pwmt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a word moves into the result register when that register is free
  // or being emptied this cycle
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  pwmt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .word   (in_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take)  in_vld_r <= 1'b1;
      else if (adv) in_vld_r <= 1'b0;
      if (adv)             out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) in_r  <= in_data;
    if (adv)     out_r <= result;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> hw/rtl/pwmt_cfg.sv
// Configuration register file of the PWM timer.
`default_nettype none
module pwmt_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [pwmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pwmt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pwmt_pkg::cfg_t                          cfg
);
  import pwmt_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prescaler  <= '0;
      cfg_r.reload     <= 16'hFFFF;
      cfg_r.repetition <= '0;
      cfg_r.count_down <= 1'b0;
      cfg_r.compare    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PRESCALER:  cfg_r.prescaler  <= cfg_data;
        REG_RELOAD:     cfg_r.reload     <= cfg_data;
        REG_REPETITION: cfg_r.repetition <= cfg_data[7:0];
        REG_COUNT_DOWN: cfg_r.count_down <= cfg_data[0];
        REG_COMPARE1:   cfg_r.compare[0] <= cfg_data;
        REG_COMPARE2:   cfg_r.compare[1] <= cfg_data;
        REG_COMPARE3:   cfg_r.compare[2] <= cfg_data;
        REG_COMPARE4:   cfg_r.compare[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> hw/rtl/pwmt_core.sv
// Timer state and the single-pass next-state and output logic.
`default_nettype none
module pwmt_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire pwmt_pkg::in_word_t  word,
  input  wire pwmt_pkg::cfg_t      cfg,
  output pwmt_pkg::out_word_t      result
);
  import pwmt_pkg::*;

  logic [15:0] pres_r, pres_nxt;
  cnt_t        period_r, period_nxt;
  logic [7:0]  rep_r, rep_nxt;
  logic        run_r, run_nxt;
  logic        evt_r, evt_nxt;
  logic        irq_on_r, irq_on_nxt;

  cnt_t        top;
  logic        irq;
  logic        wrap;
  logic [31:0] cnt_ext;
  logic [3:0]  level;

  assign top = cnt_t'(cfg.reload);

  always_comb begin
    pres_nxt   = pres_r;
    period_nxt = period_r;
    rep_nxt    = rep_r;
    run_nxt    = run_r;
    evt_nxt    = evt_r;
    irq_on_nxt = irq_on_r;
    irq        = 1'b0;
    wrap       = 1'b0;
    unique case (cmd_t'(word.command))
      CMD_TICK: begin
        if (run_r) begin
          if (pres_r >= cfg.prescaler) begin
            pres_nxt = '0;
            if (cfg.count_down) begin
              if (period_r == '0) begin
                period_nxt = top;
                wrap       = 1'b1;
              end else begin
                period_nxt = period_r - cnt_t'(1);
              end
            end else if (period_r >= top) begin
              period_nxt = '0;
              wrap       = 1'b1;
            end else begin
              period_nxt = period_r + cnt_t'(1);
            end
          end else begin
            pres_nxt = pres_r + 16'd1;
          end
        end
        // repetition count: update event only once it is exhausted
        if (wrap) begin
          if (rep_r == '0) begin
            evt_nxt = 1'b1;
            rep_nxt = cfg.repetition;
            irq     = irq_on_r;
          end else begin
            rep_nxt = rep_r - 8'd1;
          end
        end
      end
      CMD_START: begin
        if (!run_r) begin
          pres_nxt   = '0;
          rep_nxt    = cfg.repetition;
          period_nxt = cfg.count_down ? top : '0;
          run_nxt    = 1'b1;
        end
        irq_on_nxt = word.irq_enable;
      end
      CMD_STOP: begin
        run_nxt    = 1'b0;
        irq_on_nxt = 1'b0;
        pres_nxt   = '0;
        period_nxt = '0;
        rep_nxt    = '0;
      end
      CMD_CLEAR: evt_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r   <= '0;
      period_r <= '0;
      rep_r    <= '0;
      run_r    <= 1'b0;
      evt_r    <= 1'b0;
      irq_on_r <= 1'b0;
    end else if (adv) begin
      pres_r   <= pres_nxt;
      period_r <= period_nxt;
      rep_r    <= rep_nxt;
      run_r    <= run_nxt;
      evt_r    <= evt_nxt;
      irq_on_r <= irq_on_nxt;
    end
  end

  assign cnt_ext = 32'(period_nxt);

  // PWM mode 1: strict compare counting up, inclusive counting down
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      level[ch] = 1'b0;
      if (run_nxt && ch < CHANNELS) begin
        if (cfg.count_down) level[ch] = cnt_ext <= 32'(cfg.compare[ch]);
        else                level[ch] = cnt_ext <  32'(cfg.compare[ch]);
      end
    end
  end

  always_comb begin
    result.count_value       = cnt_ext[15:0];
    result.pwm_ch1           = level[0];
    result.pwm_ch2           = level[1];
    result.pwm_ch3           = level[2];
    result.pwm_ch4           = level[3];
    result.update_flag       = evt_nxt;
    result.interrupt_request = irq;
    result.running           = run_nxt;
  end

endmodule
`default_nettype wire
